>>> hdl/ttc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the time/tick converter
// no dependencies

package ttc_pkg;

   localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic CMD_NS_TO_TICKS = 1'b0;
   localparam logic CMD_TICKS_TO_NS = 1'b1;

   localparam int QUO_BITS = 32;

   // one slot of the divider chain
   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [1:0]  status;
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
   } div_stage_type;

   function automatic logic [31:0] pick_den(input logic cmd, input logic [31:0] clk_hz);
      pick_den = (cmd == CMD_NS_TO_TICKS) ? NS_PER_SEC : clk_hz;
   endfunction

   function automatic logic [31:0] pick_num(input logic cmd, input logic [31:0] clk_hz);
      pick_num = (cmd == CMD_NS_TO_TICKS) ? clk_hz : NS_PER_SEC;
   endfunction

endpackage

>>> hdl/ttc_front.sv
`timescale 1ns / 1ps
// front end: 64x32 product as two 32x32 partials, sum, range check
// depends on ttc_pkg

module ttc_front import ttc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_vld,
   input  logic          in_cmd,
   input  logic [63:0]   in_amount,
   input  logic [31:0]   clk_hz,
   output div_stage_type out_stage
);

   logic        s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in, s3_vld_ff, s3_vld_in;
   logic        s1_cmd_ff, s2_cmd_ff, s3_cmd_ff;
   logic [63:0] s1_plo_ff, s1_phi_ff;
   logic [95:0] s2_prod_ff, s2_prod_in;
   logic [1:0]  s3_status_ff, s3_status_in;
   logic [31:0] s3_rem_ff, s3_low_ff;
   logic [31:0] num1, den2;

   assign num1       = pick_num(in_cmd, clk_hz);
   assign s2_prod_in = {32'd0, s1_plo_ff} + {s1_phi_ff, 32'd0};
   assign den2       = pick_den(s2_cmd_ff, clk_hz);

   // quotient fits 32 bits only if the top part is below the divisor
   always_comb begin
      if (clk_hz == 32'd0)
         s3_status_in = ST_INVALID;
      else if (s2_prod_ff[95:32] >= {32'd0, den2})
         s3_status_in = ST_OVERFLOW;
      else
         s3_status_in = ST_OK;
   end

   assign s1_vld_in = in_vld;
   assign s2_vld_in = s1_vld_ff;
   assign s3_vld_in = s2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff    <= in_cmd;
         s1_plo_ff    <= in_amount[31:0] * num1;
         s1_phi_ff    <= in_amount[63:32] * num1;
         s2_cmd_ff    <= s1_cmd_ff;
         s2_prod_ff   <= s2_prod_in;
         s3_cmd_ff    <= s2_cmd_ff;
         s3_status_ff <= s3_status_in;
         s3_rem_ff    <= s2_prod_ff[63:32];
         s3_low_ff    <= s2_prod_ff[31:0];
      end
   end

   always_comb begin
      out_stage        = '0;
      out_stage.vld    = s3_vld_ff;
      out_stage.cmd    = s3_cmd_ff;
      out_stage.status = s3_status_ff;
      out_stage.rem    = s3_rem_ff;
      out_stage.low    = s3_low_ff;
      out_stage.quo    = '0;
   end

endmodule

>>> hdl/ttc_div_cell.sv
`timescale 1ns / 1ps
// one restoring-division cell: produces one quotient bit per beat
// depends on ttc_pkg

module ttc_div_cell import ttc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic [31:0]   clk_hz,
   input  div_stage_type prev,
   output div_stage_type next
);

   div_stage_type stage_ff, stage_in;
   logic [32:0]   trial;
   logic [31:0]   den;
   logic          take;

   assign den   = pick_den(prev.cmd, clk_hz);
   assign trial = {prev.rem, prev.low[31]};
   assign take  = trial >= {1'b0, den};

   always_comb begin
      stage_in     = prev;
      stage_in.low = {prev.low[30:0], 1'b0};
      stage_in.quo = {prev.quo[30:0], take};
      stage_in.rem = take ? 32'(trial - {1'b0, den}) : trial[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         stage_ff.vld <= 1'b0;
      else if (adv)
         stage_ff <= stage_in;
   end

   assign next = stage_ff;

endmodule

>>> hdl/time_tick_conversion.sv
`timescale 1ns / 1ps
// Converts a 64-bit duration between nanoseconds and ticks of a clock whose frequency is held
// in csr_wdata's register: result = floor(amount * num / den) with 32-bit range check. One
// beat is accepted per cycle while the result is not stalled; each result passes through two
// multiply and sum stages, one range-check stage, a chain of 32 one-bit divider cells and one
// output register. A stalled result stalls the whole pipeline. Depends on ttc_pkg, ttc_front,
// ttc_div_cell.

module time_tick_conversion import ttc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata,   // clock_hz
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // amount
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // converted
   output logic [1:0]  rsp_tuser    // status
);

   logic [31:0]   clk_hz_ff;
   logic          adv;
   div_stage_type chain [QUO_BITS+1];
   logic          out_vld_ff;
   logic [31:0]   out_data_ff, out_data_in;
   logic [1:0]    out_st_ff;

   always_ff @(posedge clock) begin
      if (reset)
         clk_hz_ff <= 32'd0;
      else if (csr_wen)
         clk_hz_ff <= csr_wdata;
   end

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   ttc_front u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(req_tvalid), .in_cmd(req_tuser), .in_amount(req_tdata),
      .clk_hz(clk_hz_ff), .out_stage(chain[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      ttc_div_cell u_cell (
         .clock(clock), .reset(reset), .adv(adv), .clk_hz(clk_hz_ff),
         .prev(chain[i]), .next(chain[i+1])
      );
   end

   assign out_data_in = (chain[QUO_BITS].status == ST_OK) ? chain[QUO_BITS].quo : 32'd0;

   always_ff @(posedge clock) begin
      if (reset)
         out_vld_ff <= 1'b0;
      else if (adv)
         out_vld_ff <= chain[QUO_BITS].vld;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
         out_st_ff   <= chain[QUO_BITS].status;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_st_ff;

endmodule

>>> hdl/ttc_checker.sv
`timescale 1ns / 1ps
// port-level checks for time_tick_conversion, bound to the top level
// depends on ttc_pkg

module ttc_checker import ttc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 32'd0)
      else $error("non-zero value with bad status");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_INVALID || rsp_tuser == ST_OVERFLOW)
      else $error("undefined status code");

   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind time_tick_conversion ttc_checker u_ttc_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
